// File: src/lpd_pkg.sv
// lpd_pkg: shared types and constants of the length-prefixed payload deframer
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2,
    PH_DROP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_BARE = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_LEADZERO = 3'd2,
    ERR_BADCHAR  = 3'd3,
    ERR_TOOLONG  = 3'd4,
    ERR_TRUNC    = 3'd5,
    ERR_BADTYPE  = 3'd6,
    ERR_DANGLING = 3'd7
  } err_e;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam int RBUF_DEPTH = 4;
  localparam int RBUF_PTR_W = $clog2(RBUF_DEPTH);
  localparam int RBUF_CNT_W = $clog2(RBUF_DEPTH + 1);

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  ptype;
    logic [7:0]  data;
    logic        first;
    logic        packet_end;
    err_e        error;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage
`default_nettype wire

// File: src/lpd_in_if.sv
// lpd_in_if: input word channel, one encoded byte plus final flag
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_final;

  modport source (output valid, output in_byte, output in_final, input ready);
  modport sink (input valid, input in_byte, input in_final, output ready);
endinterface
`default_nettype wire

// File: src/lpd_out_if.sv
// lpd_out_if: result word channel of the deframer
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface lpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [2:0] out_type;
  logic [7:0] out_data;
  logic       out_first;
  logic       out_packet_end;
  logic [2:0] out_error;
  logic       out_last;

  modport source (output valid, output out_kind, output out_type, output out_data,
                  output out_first, output out_packet_end, output out_error,
                  output out_last, input ready);
  modport sink (input valid, input out_kind, input out_type, input out_data,
                input out_first, input out_packet_end, input out_error,
                input out_last, output ready);
endinterface
`default_nettype wire

// File: src/length_prefixed_payload_deframer_core.sv
// length_prefixed_payload_deframer_core: top level, parser state and step logic
// depends on lpd_pkg, lpd_in_if, lpd_out_if and lpd_rbuf
`timescale 1ns / 1ps
`default_nettype none
// Decodes a byte stream of <decimal length>:<message> records, one byte per
// clock while the result buffer has room. The parser state is updated in the
// cycle a byte is accepted and its results (at most two words, a second one
// only on the final byte) go into a four-entry result buffer that drives the
// output channel. Input ready is high while the buffer holds two words or
// fewer, so with the output taking a word every cycle the block sustains one
// byte per cycle; a final byte that yields two words puts one extra word on
// the output. Results are registered into the buffer as the byte is accepted and leave it in order.
module length_prefixed_payload_deframer_core #(
  parameter int MAX_DIGITS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lpd_in_if.sink      in_i,
  lpd_out_if.source   out_o
);

  localparam int LenW = $clog2(10 ** MAX_DIGITS);
  localparam int CntW = $clog2(MAX_DIGITS + 1);
  localparam int MulW = LenW + 4;

  lpd_pkg::phase_e   phase_q, phase_d;
  logic [LenW-1:0]   acc_q, acc_d, left_q, left_d, left_dec;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]        type_q, type_d;
  logic              first_q, first_d;

  logic              accept, space;
  logic [7:0]        b;
  logic              is_digit;
  logic [MulW-1:0]   acc_ext, acc_mul;
  lpd_pkg::err_e     err;
  logic              step_v, fin_v;
  lpd_pkg::result_t  step_r, fin_r;
  lpd_pkg::push_t    push;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = space;
  assign b        = in_i.in_byte;
  assign is_digit = (b >= lpd_pkg::CHAR_ZERO) && (b <= lpd_pkg::CHAR_NINE);
  assign left_dec = left_q - LenW'(1);
  assign acc_ext  = MulW'(acc_q);
  assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + MulW'(b[3:0]);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    type_d  = type_q;
    first_d = first_q;
    err     = lpd_pkg::ERR_NONE;
    step_v  = 1'b0;
    step_r  = '0;
    fin_v   = 1'b0;
    fin_r   = '0;
    if (accept) begin
      unique case (phase_q)
        lpd_pkg::PH_LEN: begin
          priority if (b == lpd_pkg::CHAR_COLON) begin
            priority if (cnt_q == '0) begin
              err = lpd_pkg::ERR_EMPTY;
            end else if (acc_q == '0) begin
              cnt_d = '0;
            end else begin
              left_d  = acc_q;
              acc_d   = '0;
              cnt_d   = '0;
              phase_d = lpd_pkg::PH_TYPE;
            end
          end else if (is_digit) begin
            priority if (cnt_q == CntW'(1) && acc_q == '0) begin
              err = lpd_pkg::ERR_LEADZERO;
            end else if (cnt_q >= CntW'(MAX_DIGITS)) begin
              err = lpd_pkg::ERR_TOOLONG;
            end else begin
              acc_d = acc_mul[LenW-1:0];
              cnt_d = cnt_q + CntW'(1);
            end
          end else begin
            err = lpd_pkg::ERR_BADCHAR;
          end
        end
        lpd_pkg::PH_TYPE: begin
          priority if (b == lpd_pkg::CHAR_NUL) begin
            err = lpd_pkg::ERR_BADCHAR;
          end else if (b >= lpd_pkg::CHAR_ZERO && b <= lpd_pkg::CHAR_SIX) begin
            type_d = b[2:0];
            left_d = left_dec;
            if (left_dec == '0) begin
              step_v            = 1'b1;
              step_r.kind       = lpd_pkg::KIND_BARE;
              step_r.ptype      = b[2:0];
              step_r.packet_end = 1'b1;
              phase_d           = lpd_pkg::PH_LEN;
            end else begin
              first_d = 1'b1;
              phase_d = lpd_pkg::PH_DATA;
            end
          end else begin
            err = lpd_pkg::ERR_BADTYPE;
          end
        end
        lpd_pkg::PH_DATA: begin
          if (b == lpd_pkg::CHAR_NUL) begin
            err = lpd_pkg::ERR_BADCHAR;
          end else begin
            step_v            = 1'b1;
            step_r.kind       = lpd_pkg::KIND_DATA;
            step_r.ptype      = type_q;
            step_r.data       = b;
            step_r.first      = first_q;
            step_r.packet_end = left_q == LenW'(1);
            first_d           = 1'b0;
            left_d            = left_dec;
            if (left_dec == '0) begin
              phase_d = lpd_pkg::PH_LEN;
            end
          end
        end
        lpd_pkg::PH_DROP: begin
        end
        default: begin
        end
      endcase

      if (err != lpd_pkg::ERR_NONE) begin
        step_v       = 1'b1;
        step_r       = '0;
        step_r.kind  = lpd_pkg::KIND_ERR;
        step_r.error = err;
        phase_d      = lpd_pkg::PH_DROP;
      end else if (in_i.in_final && phase_d != lpd_pkg::PH_DROP) begin
        fin_v = 1'b1;
        priority if (phase_d == lpd_pkg::PH_TYPE || phase_d == lpd_pkg::PH_DATA) begin
          fin_r.kind  = lpd_pkg::KIND_ERR;
          fin_r.error = lpd_pkg::ERR_TRUNC;
        end else if (cnt_d != '0) begin
          fin_r.kind  = lpd_pkg::KIND_ERR;
          fin_r.error = lpd_pkg::ERR_DANGLING;
        end else begin
          fin_r.kind = lpd_pkg::KIND_DONE;
        end
      end

      if (in_i.in_final) begin
        phase_d = lpd_pkg::PH_LEN;
        acc_d   = '0;
        cnt_d   = '0;
        left_d  = '0;
        type_d  = '0;
        first_d = 1'b0;
      end
    end
  end

  always_comb begin
    push.cnt       = {1'b0, step_v} + {1'b0, fin_v};
    push.res0      = step_v ? step_r : fin_r;
    push.res0.last = !(step_v && fin_v);
    push.res1      = fin_r;
    push.res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpd_pkg::PH_LEN;
      acc_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      type_q  <= '0;
      first_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      type_q  <= type_d;
      first_q <= first_d;
    end
  end

  lpd_rbuf u_rbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.in_final) |=> (phase_q == lpd_pkg::PH_LEN && cnt_q == '0
                                   && acc_q == '0 && left_q == '0))
    else $error("state not cleared after final byte");
  a_msg_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lpd_pkg::PH_TYPE || phase_q == lpd_pkg::PH_DATA) |-> (left_q != '0))
    else $error("message phase with no bytes left");
  a_len_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_DIGITS))
    else $error("digit count beyond limit");
`endif

endmodule
`default_nettype wire

// File: src/lpd_rbuf.sv
// lpd_rbuf: result buffer, takes up to two result words per cycle, emits one
// while the output is ready; depends on lpd_pkg and lpd_out_if
`timescale 1ns / 1ps
`default_nettype none
module lpd_rbuf (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  lpd_pkg::push_t  push_i,
  output logic            space_o,
  lpd_out_if.source       out_o
);

  lpd_pkg::result_t                  mem_q [lpd_pkg::RBUF_DEPTH];
  logic [lpd_pkg::RBUF_PTR_W-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lpd_pkg::RBUF_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              pop;
  logic [lpd_pkg::RBUF_PTR_W-1:0]    wptr_nx;
  lpd_pkg::result_t                  head;

  assign pop     = out_o.valid && out_o.ready;
  assign wptr_nx = wptr_q + lpd_pkg::RBUF_PTR_W'(1);
  assign space_o = cnt_q <= lpd_pkg::RBUF_CNT_W'(lpd_pkg::RBUF_DEPTH - 2);

  always_comb begin
    wptr_d = wptr_q + lpd_pkg::RBUF_PTR_W'(push_i.cnt);
    rptr_d = rptr_q + lpd_pkg::RBUF_PTR_W'(pop);
    cnt_d  = cnt_q + lpd_pkg::RBUF_CNT_W'(push_i.cnt) - lpd_pkg::RBUF_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_nx] <= push_i.res1;
    end
  end

  assign head                 = mem_q[rptr_q];
  assign out_o.valid          = cnt_q != '0;
  assign out_o.out_kind       = head.kind;
  assign out_o.out_type       = head.ptype;
  assign out_o.out_data       = head.data;
  assign out_o.out_first      = head.first;
  assign out_o.out_packet_end = head.packet_end;
  assign out_o.out_error      = head.error;
  assign out_o.out_last       = head.last;

`ifndef SYNTHESIS
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> space_o)
    else $error("result push without room");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lpd_pkg::RBUF_CNT_W'(lpd_pkg::RBUF_DEPTH))
    else $error("result buffer overflow");
  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=>
      (cnt_q == $past(cnt_q) - lpd_pkg::RBUF_CNT_W'(1)))
    else $error("count not decremented on pop");
`endif

endmodule
`default_nettype wire

// File: tb/length_prefixed_payload_deframer_core_tb.sv
// length_prefixed_payload_deframer_core_tb: self-checking bench for the deframer core
// drives byte words with final flags, predicts each result word and checks it in order
// depends on lpd_pkg, lpd_in_if, lpd_out_if and length_prefixed_payload_deframer_core
`timescale 1ns / 1ps
module length_prefixed_payload_deframer_core_tb;

  localparam int MAX_DIGITS = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpd_in_if  in_if ();
  lpd_out_if out_if ();

  length_prefixed_payload_deframer_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  lpd_pkg::phase_e ph = lpd_pkg::PH_LEN;
  logic [26:0]     acc = '0;
  logic [3:0]      dcnt = '0;
  logic [26:0]     left = '0;
  logic [2:0]      ctype = '0;
  logic            first_p = 1'b0;

  lpd_pkg::result_t pending_results[$];
  logic [7:0]       pay_q[$];

  int src_idle_pct;
  int snk_idle_pct;
  int n_fail = 0;
  int bytes_sent;
  int payloads_sent;
  int words_checked = 0;
  int stall_cycles = 0;

  function automatic lpd_pkg::result_t mk(lpd_pkg::kind_e k, logic [2:0] t, logic [7:0] d,
                                          logic f, logic pe, lpd_pkg::err_e e);
    lpd_pkg::result_t r;
    r.kind = k;
    r.ptype = t;
    r.data = d;
    r.first = f;
    r.packet_end = pe;
    r.error = e;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void clear_deframer();
    ph = lpd_pkg::PH_LEN;
    acc = '0;
    dcnt = '0;
    left = '0;
    ctype = '0;
    first_p = 1'b0;
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic fin);
    lpd_pkg::result_t res[2];
    int n;
    lpd_pkg::err_e err;
    n = 0;
    err = lpd_pkg::ERR_NONE;
    case (ph)
      lpd_pkg::PH_LEN: begin
        if (b == lpd_pkg::CHAR_COLON) begin
          if (dcnt == 0) begin
            err = lpd_pkg::ERR_EMPTY;
          end else if (acc == 0) begin
            dcnt = '0;
          end else begin
            left = acc;
            acc = '0;
            dcnt = '0;
            ph = lpd_pkg::PH_TYPE;
          end
        end else if (b >= lpd_pkg::CHAR_ZERO && b <= lpd_pkg::CHAR_NINE) begin
          if (dcnt == 1 && acc == 0) begin
            err = lpd_pkg::ERR_LEADZERO;
          end else if (dcnt >= MAX_DIGITS) begin
            err = lpd_pkg::ERR_TOOLONG;
          end else begin
            acc = acc * 27'd10 + 27'(b - lpd_pkg::CHAR_ZERO);
            dcnt = dcnt + 4'd1;
          end
        end else begin
          err = lpd_pkg::ERR_BADCHAR;
        end
      end
      lpd_pkg::PH_TYPE: begin
        if (b == lpd_pkg::CHAR_NUL) begin
          err = lpd_pkg::ERR_BADCHAR;
        end else if (b >= lpd_pkg::CHAR_ZERO && b <= lpd_pkg::CHAR_SIX) begin
          ctype = 3'(b - lpd_pkg::CHAR_ZERO);
          left = left - 27'd1;
          if (left == 0) begin
            res[n] = mk(lpd_pkg::KIND_BARE, ctype, 8'd0, 1'b0, 1'b1, lpd_pkg::ERR_NONE);
            n++;
            ph = lpd_pkg::PH_LEN;
          end else begin
            first_p = 1'b1;
            ph = lpd_pkg::PH_DATA;
          end
        end else begin
          err = lpd_pkg::ERR_BADTYPE;
        end
      end
      lpd_pkg::PH_DATA: begin
        if (b == lpd_pkg::CHAR_NUL) begin
          err = lpd_pkg::ERR_BADCHAR;
        end else begin
          res[n] = mk(lpd_pkg::KIND_DATA, ctype, b, first_p, left == 27'd1,
                      lpd_pkg::ERR_NONE);
          n++;
          first_p = 1'b0;
          left = left - 27'd1;
          if (left == 0) ph = lpd_pkg::PH_LEN;
        end
      end
      default: ;
    endcase
    if (err != lpd_pkg::ERR_NONE) begin
      res[n] = mk(lpd_pkg::KIND_ERR, 3'd0, 8'd0, 1'b0, 1'b0, err);
      n++;
      ph = lpd_pkg::PH_DROP;
    end else if (fin && ph != lpd_pkg::PH_DROP) begin
      if (ph == lpd_pkg::PH_TYPE || ph == lpd_pkg::PH_DATA) begin
        res[n] = mk(lpd_pkg::KIND_ERR, 3'd0, 8'd0, 1'b0, 1'b0, lpd_pkg::ERR_TRUNC);
      end else if (dcnt != 0) begin
        res[n] = mk(lpd_pkg::KIND_ERR, 3'd0, 8'd0, 1'b0, 1'b0, lpd_pkg::ERR_DANGLING);
      end else begin
        res[n] = mk(lpd_pkg::KIND_DONE, 3'd0, 8'd0, 1'b0, 1'b0, lpd_pkg::ERR_NONE);
      end
      n++;
    end
    if (fin) clear_deframer();
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      n_fail++;
    end
  endtask

  // input monitor, result checker and watchdog
  always @(posedge clk_i) begin
    lpd_pkg::result_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) deframe_byte(in_if.in_byte, in_if.in_final);
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word, kind %0d error %0d", out_if.out_kind,
                 out_if.out_error);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_kind", want.kind, out_if.out_kind);
          check_field("out_type", want.ptype, out_if.out_type);
          check_field("out_data", want.data, out_if.out_data);
          check_field("out_first", want.first, out_if.out_first);
          check_field("out_packet_end", want.packet_end, out_if.out_packet_end);
          check_field("out_error", want.error, out_if.out_error);
          check_field("out_last", want.last, out_if.out_last);
          words_checked++;
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_word(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_final <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_payload();
    for (int i = 0; i < pay_q.size(); i++) send_word(pay_q[i], i == pay_q.size() - 1);
    pay_q.delete();
    payloads_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) pay_q.push_back(s[i]);
  endtask

  task automatic add_record(input int type_idx, input int n_data);
    add_text($sformatf("%0d:", n_data + 1));
    pay_q.push_back(8'(lpd_pkg::CHAR_ZERO + type_idx));
    repeat (n_data) pay_q.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic test_clean_records();
    // skipped record, bare type 6, type 0 with one data byte of all ones
    add_text("0:1:62:0");
    pay_q.push_back(8'hFF);
    send_payload();
    add_record(3, 4);
    send_payload();
  endtask

  task automatic test_length_errors();
    add_text(":ab");
    send_payload();
    add_text("07");
    send_payload();
    pay_q.push_back(lpd_pkg::CHAR_NUL);
    send_payload();
    add_text("123456789");
    send_payload();
    add_text("5");
    send_payload();
  endtask

  task automatic test_message_errors();
    add_text("1:");
    pay_q.push_back(lpd_pkg::CHAR_NUL);
    send_payload();
    add_text("1:7");
    send_payload();
    add_text("3:1a");
    send_payload();
  endtask

  task automatic random_payload();
    int n_rec;
    int n_data;
    n_rec = $urandom_range(1, 4);
    repeat (n_rec) begin
      if ($urandom_range(9) == 0) begin
        add_text("0:");
      end else begin
        n_data = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 6);
        add_record($urandom_range(0, 6), n_data);
      end
    end
    case ($urandom_range(0, 11))
      0: pay_q = pay_q[0:$urandom_range(0, pay_q.size() - 2)];
      1: pay_q[$urandom_range(0, pay_q.size() - 1)] = 8'($urandom_range(0, 255));
      2: add_text($sformatf("%0d", $urandom_range(1, 999)));
      3: begin
        pay_q.delete();
        repeat ($urandom_range(1, 6)) pay_q.push_back(8'($urandom_range(0, 255)));
      end
      4: begin
        if ($urandom_range(1))
          add_text($sformatf("%0d:", $urandom_range(10000000, 99999999)));
        else
          add_text($sformatf("%0d:", $urandom_range(100000000, 999999999)));
        pay_q.push_back(8'(lpd_pkg::CHAR_ZERO + $urandom_range(0, 6)));
        repeat ($urandom_range(0, 3)) pay_q.push_back(8'($urandom_range(1, 255)));
      end
      5: pay_q.push_front(lpd_pkg::CHAR_ZERO);
      default: ;
    endcase
    send_payload();
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_bytes);
    int start;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) random_payload();
  endtask

  initial begin
    bytes_sent = 0;
    payloads_sent = 0;
    src_idle_pct = 30;
    snk_idle_pct = 81;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.in_byte <= 8'd0;
    in_if.in_final <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_clean_records();
    test_length_errors();
    test_message_errors();
    test_random_traffic(30, 81, 450);
    test_random_traffic(81, 30, 450);
    test_random_traffic(0, 0, 450);

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("sent %0d bytes in %0d payloads, checked %0d result words", bytes_sent,
             payloads_sent, words_checked);
    $display("clean records, every length and message error, three idle mixes");
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: length_prefixed_payload_deframer_core.f
src/lpd_pkg.sv
src/lpd_in_if.sv
src/lpd_out_if.sv
src/lpd_rbuf.sv
src/length_prefixed_payload_deframer_core.sv
tb/length_prefixed_payload_deframer_core_tb.sv
